>>> rtl/matrix3x3_inverse_unit_assert.svh
// assertion macros used by the port-level checker of the 3x3 inverse unit
`ifndef MATRIX3X3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3X3_INVERSE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MI3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mi3_pkg.sv
// types, widths and cofactor tables of the 3x3 inverse unit
`default_nettype none
package mi3_pkg;

  localparam int N_EL        = 9;
  localparam int IDX_W       = $clog2(N_EL);
  localparam int DET_TERMS   = 3;
  localparam int DW          = 32;   // element width, Q16.16
  localparam int PW          = 64;   // product of two elements
  localparam int CW          = 65;   // exact cofactor
  localparam int MW          = 64;   // cofactor magnitude
  localparam int HW          = 32;   // half of a cofactor magnitude
  localparam int DETW        = 97;   // exact determinant
  localparam int DMAGW       = 96;   // determinant magnitude
  localparam int REMW        = 96;   // divider partial remainder
  localparam int QW          = 33;   // quotient bits kept
  localparam int DIV_STEPS   = 33;   // one quotient bit per stage
  localparam int FRONT_STAGES = 8;

  typedef logic signed [DW-1:0]    elem_t;
  typedef logic        [DW-1:0]    uelem_t;
  typedef logic signed [PW-1:0]    prod_t;
  typedef logic        [PW-1:0]    umul_t;
  typedef logic signed [CW-1:0]    cof_t;
  typedef logic        [MW-1:0]    mag_t;
  typedef logic signed [DETW-1:0]  det_t;
  typedef logic        [DMAGW-1:0] dmag_t;
  typedef logic        [REMW-1:0]  rem_t;
  typedef logic        [QW-1:0]    quo_t;
  typedef logic [N_EL-1:0][MW-1:0] mag_arr_t;

  // clamp limits of the quotient magnitude
  localparam quo_t SAT_POS = quo_t'((64'd1 << (DW - 1)) - 64'd1);
  localparam quo_t SAT_NEG = quo_t'(64'd1 << (DW - 1));

  // adjugate entry k = m[A]*m[B] - m[C]*m[D]
  localparam logic [IDX_W-1:0] COF_A [N_EL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam logic [IDX_W-1:0] COF_B [N_EL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam logic [IDX_W-1:0] COF_C [N_EL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam logic [IDX_W-1:0] COF_D [N_EL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // determinant data shared by all divider lanes
  typedef struct packed {
    logic  singular;
    logic  det_neg;
    dmag_t dmag;
  } lane_ctl_t;

  // one finished result
  typedef struct packed {
    logic [N_EL-1:0][DW-1:0] r;
    logic                    singular;
    logic                    saturated;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/mi3_front.sv
// cofactor and determinant pipeline, eight register stages
`default_nettype none
module mi3_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire mi3_pkg::elem_t        m [mi3_pkg::N_EL],
  output logic                       out_valid,
  output mi3_pkg::mag_arr_t          am,
  output logic [mi3_pkg::N_EL-1:0]   an,
  output mi3_pkg::lane_ctl_t         ctl
);
  import mi3_pkg::*;

  logic [FRONT_STAGES-1:0] vs;
  prod_t     pp1 [N_EL];
  prod_t     pn1 [N_EL];
  elem_t     a1 [DET_TERMS];
  elem_t     a2 [DET_TERMS];
  cof_t      adj2 [N_EL];
  mag_arr_t  am_pipe [6];
  logic [N_EL-1:0] an_pipe [6];
  uelem_t    aa3 [DET_TERMS];
  logic      [DET_TERMS-1:0] sg3, sg4, sg5;
  umul_t     pl4 [DET_TERMS];
  umul_t     ph4 [DET_TERMS];
  dmag_t     t5 [DET_TERMS];
  det_t      st6 [DET_TERMS];
  det_t      det7;
  lane_ctl_t ctl8;

  // valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[FRONT_STAGES-2:0], in_valid};
    end
  end

  // stage 1: the eighteen element products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_EL; k++) begin
        pp1[k] <= prod_t'(m[COF_A[k]]) * prod_t'(m[COF_B[k]]);
        pn1[k] <= prod_t'(m[COF_C[k]]) * prod_t'(m[COF_D[k]]);
      end
      for (int i = 0; i < DET_TERMS; i++) a1[i] <= m[i];
    end
  end

  // stage 2: exact cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_EL; k++) adj2[k] <= cof_t'(pp1[k]) - cof_t'(pn1[k]);
      for (int i = 0; i < DET_TERMS; i++) a2[i] <= a1[i];
    end
  end

  // stage 3: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_EL; k++) begin
        am_pipe[0][k] <= mag_t'(adj2[k][CW-1] ? -adj2[k] : adj2[k]);
        an_pipe[0][k] <= adj2[k][CW-1];
      end
      for (int i = 0; i < DET_TERMS; i++) begin
        aa3[i] <= a2[i][DW-1] ? uelem_t'(-a2[i]) : uelem_t'(a2[i]);
        sg3[i] <= a2[i][DW-1] ^ adj2[3*i][CW-1];
      end
    end
  end

  // carry the adjugate magnitudes to the divider entry
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 1; j < 6; j++) begin
        am_pipe[j] <= am_pipe[j-1];
        an_pipe[j] <= an_pipe[j-1];
      end
    end
  end

  // stage 4: determinant partial products, 32x32 each
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DET_TERMS; i++) begin
        pl4[i] <= umul_t'(aa3[i]) * umul_t'(am_pipe[0][3*i][HW-1:0]);
        ph4[i] <= umul_t'(aa3[i]) * umul_t'(am_pipe[0][3*i][MW-1:HW]);
      end
      sg4 <= sg3;
    end
  end

  // stage 5: join the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DET_TERMS; i++) begin
        t5[i] <= dmag_t'(pl4[i]) + (dmag_t'(ph4[i]) << HW);
      end
      sg5 <= sg4;
    end
  end

  // stage 6: apply term signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DET_TERMS; i++) begin
        st6[i] <= sg5[i] ? -det_t'(t5[i]) : det_t'(t5[i]);
      end
    end
  end

  // stage 7: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det7 <= st6[0] + st6[1] + st6[2];
    end
  end

  // stage 8: determinant magnitude and zero test
  always_ff @(posedge clk) begin
    if (en) begin
      ctl8.singular <= (det7 == '0);
      ctl8.det_neg  <= det7[DETW-1];
      ctl8.dmag     <= dmag_t'(det7[DETW-1] ? -det7 : det7);
    end
  end

  assign out_valid = vs[FRONT_STAGES-1];
  assign am        = am_pipe[5];
  assign an        = an_pipe[5];
  assign ctl       = ctl8;

endmodule
`default_nettype wire

>>> rtl/mi3_div_lane.sv
// one restoring divider lane, one quotient bit per stage, with clamping
`default_nettype none
module mi3_div_lane (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire mi3_pkg::mag_t        am,
  input  wire logic                 an,
  input  wire mi3_pkg::lane_ctl_t   ctl [mi3_pkg::DIV_STEPS],
  output mi3_pkg::uelem_t           r,
  output logic                      sat
);
  import mi3_pkg::*;

  rem_t rem_in [DIV_STEPS];
  rem_t rem_q  [DIV_STEPS];
  quo_t q_in   [DIV_STEPS];
  quo_t q_q    [DIV_STEPS];
  logic [DIV_STEPS-1:0] ovf_in, ovf_q, neg_in, neg_q;
  quo_t qf, lim, val;
  logic qneg;

  // entry: top part of the dividend and the early overflow test
  assign rem_in[0] = rem_t'(am >> 1);
  assign q_in[0]   = '0;
  assign ovf_in[0] = dmag_t'(am >> 1) >= ctl[0].dmag;
  assign neg_in[0] = an ^ ctl[0].det_neg;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic          bin;
    logic [REMW:0] sh, df;

    // only the first step brings in a dividend bit; the rest are zeros
    if (s == 0) begin : g_first
      assign bin = am[0];
    end else begin : g_rest
      assign bin = 1'b0;
      assign rem_in[s] = rem_q[s-1];
      assign q_in[s]   = q_q[s-1];
      assign ovf_in[s] = ovf_q[s-1];
      assign neg_in[s] = neg_q[s-1];
    end

    // trial subtract
    assign sh = {rem_in[s], bin};
    assign df = sh - {1'b0, ctl[s].dmag};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= df[REMW] ? sh[REMW-1:0] : df[REMW-1:0];
        q_q[s]   <= {q_in[s][QW-2:0], ~df[REMW]};
        ovf_q[s] <= ovf_in[s];
        neg_q[s] <= neg_in[s];
      end
    end
  end

  // clamp and sign
  always_comb begin
    qf   = q_q[DIV_STEPS-1];
    qneg = neg_q[DIV_STEPS-1];
    lim  = qneg ? SAT_NEG : SAT_POS;
    sat  = ovf_q[DIV_STEPS-1] || (qf > lim);
    val  = sat ? lim : qf;
    r    = qneg ? uelem_t'(-val) : uelem_t'(val);
  end

endmodule
`default_nettype wire

>>> rtl/mi3_skid.sv
// output register with a skid entry so the pipeline runs while a result waits
`default_nettype none
module mi3_skid (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire mi3_pkg::out_item_t  in_item,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mi3_pkg::out_item_t       out_item
);
  import mi3_pkg::*;

  logic      ov, sv, take, moving;
  out_item_t ob, sb;

  assign take   = in_valid && !sv;
  assign moving = !ov || !out_stall;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (moving) begin
      ov <= sv || take;
      sv <= 1'b0;
    end else if (take) begin
      sv <= 1'b1;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (moving) begin
      ob <= sv ? sb : in_item;
    end else if (take) begin
      sb <= in_item;
    end
  end

  assign full      = sv;
  assign out_valid = ov;
  assign out_item  = ob;

endmodule
`default_nettype wire

>>> rtl/matrix3x3_inverse_unit.sv
// top level of the 3x3 matrix inverse unit (adjugate over exact determinant)
//
//   channel   signals                          payload
//   src       src_valid / src_stall (out)      m0..m8, signed Q16.16
//   res       res_valid / res_stall (in)       r0..r8, singular, saturated
//
// one matrix accepted per cycle while src_stall is low; 8 cofactor and
// determinant stages, 33 divider stages (one quotient bit each), 1 output reg
// src_stall rises only when a result is held and the skid entry is full;
// then the whole pipeline freezes, nothing is dropped or repeated
// rst is synchronous; it clears the valid bits only
`default_nettype none
module matrix3x3_inverse_unit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           src_valid,
  output logic                src_stall,
  input  wire mi3_pkg::elem_t m0,
  input  wire mi3_pkg::elem_t m1,
  input  wire mi3_pkg::elem_t m2,
  input  wire mi3_pkg::elem_t m3,
  input  wire mi3_pkg::elem_t m4,
  input  wire mi3_pkg::elem_t m5,
  input  wire mi3_pkg::elem_t m6,
  input  wire mi3_pkg::elem_t m7,
  input  wire mi3_pkg::elem_t m8,
  output logic                res_valid,
  input  wire logic           res_stall,
  output mi3_pkg::elem_t      r0,
  output mi3_pkg::elem_t      r1,
  output mi3_pkg::elem_t      r2,
  output mi3_pkg::elem_t      r3,
  output mi3_pkg::elem_t      r4,
  output mi3_pkg::elem_t      r5,
  output mi3_pkg::elem_t      r6,
  output mi3_pkg::elem_t      r7,
  output mi3_pkg::elem_t      r8,
  output logic                singular,
  output logic                saturated
);
  import mi3_pkg::*;

  logic      en, skid_full, front_v;
  elem_t     m_arr [N_EL];
  mag_arr_t  am;
  logic [N_EL-1:0] an, lane_sat;
  uelem_t    lane_r [N_EL];
  lane_ctl_t ctl_d [DIV_STEPS];
  lane_ctl_t ctl_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] vd;
  out_item_t pipe_item, out_item;

  assign en        = !skid_full;
  assign src_stall = skid_full;

  assign m_arr[0] = m0;
  assign m_arr[1] = m1;
  assign m_arr[2] = m2;
  assign m_arr[3] = m3;
  assign m_arr[4] = m4;
  assign m_arr[5] = m5;
  assign m_arr[6] = m6;
  assign m_arr[7] = m7;
  assign m_arr[8] = m8;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (src_valid),
    .m         (m_arr),
    .out_valid (front_v),
    .am        (am),
    .an        (an),
    .ctl       (ctl_d[0])
  );

  // shared determinant data and valid bits through the divider stages
  for (genvar s = 1; s < DIV_STEPS; s++) begin : g_ctl
    assign ctl_d[s] = ctl_r[s-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) ctl_r[s] <= ctl_d[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else if (en) begin
      vd <= {vd[DIV_STEPS-2:0], front_v};
    end
  end

  // nine divider lanes
  for (genvar k = 0; k < N_EL; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .am  (am[k]),
      .an  (an[k]),
      .ctl (ctl_d),
      .r   (lane_r[k]),
      .sat (lane_sat[k])
    );
  end

  // zero the result and the clamp flag of a singular matrix
  always_comb begin
    pipe_item.singular  = ctl_r[DIV_STEPS-1].singular;
    pipe_item.saturated = !ctl_r[DIV_STEPS-1].singular && (|lane_sat);
    for (int k = 0; k < N_EL; k++) begin
      pipe_item.r[k] = ctl_r[DIV_STEPS-1].singular ? '0 : lane_r[k];
    end
  end

  mi3_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd[DIV_STEPS-1]),
    .in_item   (pipe_item),
    .full      (skid_full),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_item  (out_item)
  );

  assign r0        = elem_t'(out_item.r[0]);
  assign r1        = elem_t'(out_item.r[1]);
  assign r2        = elem_t'(out_item.r[2]);
  assign r3        = elem_t'(out_item.r[3]);
  assign r4        = elem_t'(out_item.r[4]);
  assign r5        = elem_t'(out_item.r[5]);
  assign r6        = elem_t'(out_item.r[6]);
  assign r7        = elem_t'(out_item.r[7]);
  assign r8        = elem_t'(out_item.r[8]);
  assign singular  = out_item.singular;
  assign saturated = out_item.saturated;

endmodule
`default_nettype wire

>>> rtl/mi3_checker.sv
// port-level checks of the 3x3 inverse unit and their binding
`default_nettype none
`include "matrix3x3_inverse_unit_assert.svh"
module mi3_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           src_valid,
  input wire logic           src_stall,
  input wire mi3_pkg::elem_t m0,
  input wire mi3_pkg::elem_t m1,
  input wire mi3_pkg::elem_t m2,
  input wire mi3_pkg::elem_t m3,
  input wire mi3_pkg::elem_t m4,
  input wire mi3_pkg::elem_t m5,
  input wire mi3_pkg::elem_t m6,
  input wire mi3_pkg::elem_t m7,
  input wire mi3_pkg::elem_t m8,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire mi3_pkg::elem_t r0,
  input wire mi3_pkg::elem_t r1,
  input wire mi3_pkg::elem_t r2,
  input wire mi3_pkg::elem_t r3,
  input wire mi3_pkg::elem_t r4,
  input wire mi3_pkg::elem_t r5,
  input wire mi3_pkg::elem_t r6,
  input wire mi3_pkg::elem_t r7,
  input wire mi3_pkg::elem_t r8,
  input wire logic           singular,
  input wire logic           saturated
);
  import mi3_pkg::*;

  logic                   held, sing_ok;
  logic [N_EL*DW+1:0]     res_word;

  // result held back by the receiver
  assign held = res_valid && res_stall;

  // whole result payload
  assign res_word = {r0, r1, r2, r3, r4, r5, r6, r7, r8, singular, saturated};

  // all elements zero and no clamp flag
  assign sing_ok = ~|{r0, r1, r2, r3, r4, r5, r6, r7, r8} && !saturated;

  // a singular matrix gives an all-zero, unclamped result
  `MI3_ASSERT_IMP(a_singular_zero, res_valid && singular, sing_ok, "singular result not zero")

  // the source side stalls only after a held result
  `MI3_ASSERT_IMP(a_stall_cause, src_stall, $past(held), "src_stall without a held result")

  // a held result stays put
  `MI3_ASSERT_NXT(a_res_hold, held, res_valid && $stable(res_word), "held result changed")

endmodule

bind matrix3x3_inverse_unit mi3_checker u_mi3_checker (.*);
`default_nettype wire

>>> bench/mi3_checker.sv
// result checker of the 3x3 inverse unit: predicts each inverse and compares it
`timescale 1ns / 100ps
module mi3_result_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     src_valid,
  input  logic                                     src_stall,
  input  logic [mi3_pkg::N_EL-1:0][mi3_pkg::DW-1:0] mat,
  input  logic                                     res_valid,
  input  logic                                     res_stall,
  input  mi3_pkg::out_item_t                       res,
  output int                                       fails,
  output int                                       pending,
  output int                                       n_singular,
  output int                                       n_saturated
);
  import mi3_pkg::*;

  out_item_t inverse_q[$];

  // exact 2x2 cofactor p*q - r*s
  function automatic logic signed [127:0] cofactor(input logic signed [31:0] p, q, r, s);
    logic signed [127:0] pp, qq, rr, ss;
    pp = p;
    qq = q;
    rr = r;
    ss = s;
    return pp * qq - rr * ss;
  endfunction

  // adjugate over exact determinant, truncated toward zero and clamped
  function automatic out_item_t invert3(input logic [N_EL-1:0][DW-1:0] a);
    logic signed [127:0] adj [N_EL];
    logic signed [127:0] det, e0, e1, e2;
    logic [127:0] dmag, amag, num, quo, limit;
    logic neg;
    out_item_t o;
    adj[0] = cofactor(a[4], a[8], a[5], a[7]);
    adj[1] = cofactor(a[2], a[7], a[1], a[8]);
    adj[2] = cofactor(a[1], a[5], a[2], a[4]);
    adj[3] = cofactor(a[5], a[6], a[3], a[8]);
    adj[4] = cofactor(a[0], a[8], a[2], a[6]);
    adj[5] = cofactor(a[2], a[3], a[0], a[5]);
    adj[6] = cofactor(a[3], a[7], a[4], a[6]);
    adj[7] = cofactor(a[1], a[6], a[0], a[7]);
    adj[8] = cofactor(a[0], a[4], a[1], a[3]);
    e0 = $signed(a[0]);
    e1 = $signed(a[1]);
    e2 = $signed(a[2]);
    det = e0 * adj[0] + e1 * adj[3] + e2 * adj[6];
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    dmag = (det < 0) ? -det : det;
    for (int k = 0; k < N_EL; k++) begin
      amag = (adj[k] < 0) ? -adj[k] : adj[k];
      neg = (adj[k] < 0) != (det < 0);
      num = amag << 32;
      quo = num / dmag;
      limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (quo > limit) begin
        quo = limit;
        o.saturated = 1'b1;
      end
      o.r[k] = neg ? -quo[31:0] : quo[31:0];
    end
    return o;
  endfunction

  // track accepted requests and compare finished results
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      fails <= 0;
      n_singular <= 0;
      n_saturated <= 0;
    end else begin
      if (src_valid && !src_stall)
        inverse_q.push_back(invert3(mat));
      if (res_valid && !res_stall) begin
        if (inverse_q.size() == 0) begin
          if (fails < 10)
            $display("ERROR: result with no request pending r0=%h", res.r[0]);
          fails <= fails + 1;
        end else begin
          want = inverse_q.pop_front();
          n_singular <= n_singular + want.singular;
          n_saturated <= n_saturated + want.saturated;
          if (res !== want) begin
            if (fails < 10) begin
              $display("ERROR: inverse mismatch singular %b/%b saturated %b/%b",
                       want.singular, res.singular, want.saturated, res.saturated);
              for (int k = 0; k < N_EL; k++)
                if (res.r[k] !== want.r[k])
                  $display("  r%0d expected %h got %h", k, want.r[k], res.r[k]);
            end
            fails <= fails + 1;
          end
        end
      end
    end
    pending <= inverse_q.size();
  end

endmodule

>>> bench/tb_top.sv
// stimulus, flow control and verdict for the 3x3 inverse unit
`timescale 1ns / 100ps
module tb_top;
  import mi3_pkg::*;

  localparam int N_RANDOM = 430;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  logic clk;
  logic rst;
  logic src_valid;
  logic src_stall;
  logic res_valid;
  logic res_stall;
  logic [N_EL-1:0][DW-1:0] mat;
  out_item_t res;
  int fails, pending, n_singular, n_saturated;
  int cycles = 0;
  int sent;
  logic pressure_done;

  matrix3x3_inverse_unit u_top (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall),
    .m0(mat[0]), .m1(mat[1]), .m2(mat[2]), .m3(mat[3]), .m4(mat[4]),
    .m5(mat[5]), .m6(mat[6]), .m7(mat[7]), .m8(mat[8]),
    .res_valid(res_valid), .res_stall(res_stall),
    .r0(res.r[0]), .r1(res.r[1]), .r2(res.r[2]), .r3(res.r[3]), .r4(res.r[4]),
    .r5(res.r[5]), .r6(res.r[6]), .r7(res.r[7]), .r8(res.r[8]),
    .singular(res.singular), .saturated(res.saturated)
  );

  mi3_result_checker u_checker (
    .clk(clk), .rst(rst), .src_valid(src_valid), .src_stall(src_stall), .mat(mat),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .fails(fails), .pending(pending),
    .n_singular(n_singular), .n_saturated(n_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix3x3_inverse_unit verification failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // offer one request and hold it until accepted, then maybe idle
  task automatic send_matrix(input logic [N_EL-1:0][DW-1:0] m);
    int idle;
    src_valid <= 1'b1;
    mat <= m;
    do @(posedge clk); while (src_stall);
    sent++;
    idle = gap_len();
    if (idle > 0) begin
      src_valid <= 1'b0;
      mat <= {N_EL{$urandom()}};
      repeat (idle) @(posedge clk);
    end
  endtask

  function automatic logic [N_EL-1:0][DW-1:0] diag3(input logic [31:0] x, y, z);
    logic [N_EL-1:0][DW-1:0] m;
    m = '0;
    m[0] = x;
    m[4] = y;
    m[8] = z;
    return m;
  endfunction

  // small Q16.16 value within about +-8.0
  function automatic logic [31:0] small_q();
    return $unsigned(32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000));
  endfunction

  function automatic logic [N_EL-1:0][DW-1:0] random_matrix();
    logic [N_EL-1:0][DW-1:0] m;
    int kind;
    int row;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < N_EL; k++)
      m[k] = (kind < 6) ? small_q() : $urandom();
    // singular by a repeated row or column
    if (kind == 5) begin
      row = $urandom_range(0, 2);
      for (int c = 0; c < 3; c++)
        m[((row + 1) % 3) * 3 + c] = m[row * 3 + c];
    end else if (kind == 4) begin
      for (int r = 0; r < 3; r++)
        m[r * 3 + 2] = m[r * 3];
    end else if (kind == 9) begin
      // tiny values give huge inverses
      for (int k = 0; k < N_EL; k++)
        m[k] = $unsigned(32'($signed($urandom_range(0, 6)) - 3));
    end
    return m;
  endfunction

  // receiver flow control with one long hold-off
  initial begin
    int len;
    res_stall <= 1'b1;
    pressure_done = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!pressure_done && sent > 120) begin
        pressure_done = 1'b1;
        res_stall <= 1'b1;
        len = 300;
      end else if ($urandom_range(0, 9) == 0) begin
        res_stall <= 1'b0;
        len = $urandom_range(30, 80);
      end else begin
        res_stall <= ($urandom_range(0, 3) == 0);
        len = gap_len() + 1;
      end
      repeat (len) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    logic [N_EL-1:0][DW-1:0] m;
    int wait_cycles;
    sent = 0;
    rst <= 1'b1;
    src_valid <= 1'b0;
    mat <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: identity, scaling, singular, extremes, clamp boundary
    send_matrix(diag3(ONE, ONE, ONE));
    send_matrix(diag3(32'h0002_0000, 32'h0000_8000, 32'hfffc_0000));
    send_matrix('0);
    send_matrix({N_EL{MAXV}});
    send_matrix({N_EL{MINV}});
    send_matrix(diag3(MINV, MINV, MINV));
    send_matrix(diag3(MAXV, MAXV, MAXV));
    send_matrix(diag3(MINV, MAXV, MINV));
    send_matrix(diag3(32'd1, 32'd1, 32'd1));
    send_matrix(diag3(32'hffff_fffe, 32'd2, ONE));
    send_matrix(diag3(32'd2, 32'd2, 32'd2));
    send_matrix(diag3(32'hffff_ffff, ONE, ONE));
    send_matrix(diag3(ONE, 32'd0, ONE));
    m = {32'h0009_0000, 32'h0008_0000, 32'h0007_0000, 32'h0006_0000, 32'h0005_0000,
         32'h0004_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
    send_matrix(m);
    m = {ONE, 32'h0000_0000, 32'h0002_0000, 32'hffff_0000, 32'h0003_0000,
         32'h0001_8000, 32'h0000_4000, ONE, 32'hfffe_0000};
    send_matrix(m);
    m = {MAXV, MINV, ONE, 32'd0, 32'hffff_ffff, MAXV, MINV, 32'd1, 32'h5555_5555};
    send_matrix(m);
    m = {32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0001,
         32'h7fff_fffe, 32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f};
    send_matrix(m);

    // random matrices
    repeat (N_RANDOM) send_matrix(random_matrix());
    src_valid <= 1'b0;

    // drain, then a short quiet tail
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);

    $display("sent %0d matrices: %0d singular, %0d with clamped elements, stall pressure %0s",
             sent, n_singular, n_saturated, pressure_done ? "applied" : "not reached");
    if (fails == 0 && pending == 0)
      $display("matrix3x3_inverse_unit verification clean");
    else
      $display("matrix3x3_inverse_unit verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_lane.sv
rtl/mi3_skid.sv
rtl/matrix3x3_inverse_unit.sv
rtl/mi3_checker.sv
bench/mi3_checker.sv
bench/tb_top.sv
